FILE: src/assert_macros.svh
// Assertion macros for the checker file kkf_checker.sv.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define KKF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define KKF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/kkf_pkg.sv
// Shared constants, types and helper functions of the Koch fold step unit.
// Depends on nothing; the top level, front end, square root and divider files import it.
package kkf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_WTS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_WIN = 3'd6;

  // Per-item data that rides alongside the length and divide pipes
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] nw;
    logic signed [31:0] nde;
    logic [30:0]        dist_in;
    logic signed [31:0] color;
    logic signed [17:0] col;
    logic               hit;
  } side_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Magnitude of a 32-bit signed value, exact for the most negative code
  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: src/kkf_if.sv
// Valid/ready channels for input items and results of the fold step unit.
// Depends on nothing but plain logic types.
interface kkf_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] point_w;
  logic signed [31:0] derivative_in;
  logic [30:0]        distance_in;
  logic signed [31:0] color_in;
  logic [15:0]        iteration;

  modport source(output valid, point_x, point_y, point_z, point_w, derivative_in,
                 distance_in, color_in, iteration, input ready);
  modport sink(input valid, point_x, point_y, point_z, point_w, derivative_in,
               distance_in, color_in, iteration, output ready);
endinterface

interface kkf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic signed [31:0] new_w;
  logic signed [31:0] derivative_out;
  logic [30:0]        distance_out;
  logic signed [31:0] color_out;

  modport source(output valid, new_x, new_y, new_z, new_w, derivative_out,
                 distance_out, color_out, input ready);
  modport sink(input valid, new_x, new_y, new_z, new_w, derivative_out,
               distance_out, color_out, output ready);
endinterface

FILE: src/koch_kifs_fold_step_unit.sv
// Top level of the Koch fold step unit: config registers, pipe chaining, output stage.
// Depends on kkf_pkg, kkf_if, kkf_front, kkf_sqrt_pipe and kkf_div_pipe.
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+------------------------------------------
//   item     | in  | valid/ready    | point, derivative, distance, colour, iter
//   result   | out | valid/ready    | new point, derivative, distance, colour
//   cfg      | in  | cfg_we only    | register index and 48-bit data
//
// One item per cycle while no result waits (Q16.16 by default). The pipe has
// 8 front stages, 32 square root stages, 1 difference stage, 33 + FRACTION_BITS
// divider stages and the output register. The divider depth sets the latency.
// Reset clears every valid bit and loads the register defaults.
// When a result waits and is not taken, the whole pipe holds and ready drops.
module koch_kifs_fold_step_unit #(
  parameter int FRACTION_BITS = kkf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  kkf_item_if.sink                        item,
  kkf_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [kkf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kkf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kkf_pkg::*;

  localparam int WSH = FRACTION_BITS - 8;

  logic signed [31:0] y_fold_scale, main_scale, offset_x, offset_y, offset_z;
  logic [47:0]        swap_color_weights;
  logic [32:0]        color_window;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      y_fold_scale       <= 32'(longint'(1) << FRACTION_BITS);
      main_scale         <= 32'(longint'(3) << FRACTION_BITS);
      offset_x           <= 32'(longint'(1) << FRACTION_BITS);
      offset_y           <= '0;
      offset_z           <= '0;
      swap_color_weights <= '0;
      color_window       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_Y_FOLD:     y_fold_scale       <= cfg_data[31:0];
        CFG_MAIN_SCALE: main_scale         <= cfg_data[31:0];
        CFG_OFFSET_X:   offset_x           <= cfg_data[31:0];
        CFG_OFFSET_Y:   offset_y           <= cfg_data[31:0];
        CFG_OFFSET_Z:   offset_z           <= cfg_data[31:0];
        CFG_SWAP_WTS:   swap_color_weights <= cfg_data[47:0];
        CFG_COLOR_WIN:  color_window       <= cfg_data[32:0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything while a result waits
  logic en;
  logic res_valid;

  assign en          = !res_valid || result.ready;
  assign item.ready  = en;

  logic        f_valid;
  logic [63:0] pt_sq_sum, off_sq_sum;
  side_t       f_side;

  kkf_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(item.valid),
    .point_x(item.point_x), .point_y(item.point_y), .point_z(item.point_z),
    .point_w(item.point_w), .derivative_in(item.derivative_in),
    .distance_in(item.distance_in), .color_in(item.color_in),
    .iteration(item.iteration),
    .y_fold_scale(y_fold_scale), .main_scale(main_scale),
    .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
    .swap_color_weights(swap_color_weights), .color_window(color_window),
    .out_valid(f_valid), .pt_sq_sum(pt_sq_sum), .off_sq_sum(off_sq_sum),
    .side(f_side)
  );

  logic        q_valid;
  logic [31:0] pt_root, off_root;
  side_t       q_side;

  kkf_sqrt_pipe u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .pt_val(pt_sq_sum), .off_val(off_sq_sum), .side_in(f_side),
    .out_valid(q_valid), .pt_root(pt_root), .off_root(off_root),
    .side_out(q_side)
  );

  // length difference and divisor magnitude
  logic                      d_valid;
  logic [FRACTION_BITS+32:0] d_num;
  logic [31:0]               d_den;
  side_t                     d_side;
  logic [31:0]               ldiff;

  assign ldiff = (pt_root >= off_root) ? (pt_root - off_root) : (off_root - pt_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num  <= {1'b0, ldiff, {FRACTION_BITS{1'b0}}};
      d_den  <= mag(q_side.nde);
      d_side <= q_side;
    end
  end

  logic        v_valid;
  logic [30:0] v_dist;
  side_t       v_side;

  kkf_div_pipe #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid),
    .num(d_num), .den(d_den), .side_in(d_side),
    .out_valid(v_valid), .dist_q(v_dist), .side_out(v_side)
  );

  // colour update inside the window when the distance moved
  logic               hit;
  logic signed [41:0] wt, csum;
  logic signed [31:0] color_next;

  always_comb begin
    hit        = v_side.hit && (v_dist != v_side.dist_in);
    wt         = 42'(v_side.col) <<< WSH;
    csum       = 42'(v_side.color) + wt;
    color_next = hit ? sat32(64'(csum)) : v_side.color;
  end

  // output register
  logic signed [31:0] r_x, r_y, r_z, r_w, r_de, r_color;
  logic [30:0]        r_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x     <= v_side.nx;
      r_y     <= v_side.ny;
      r_z     <= v_side.nz;
      r_w     <= v_side.nw;
      r_de    <= v_side.nde;
      r_dist  <= v_dist;
      r_color <= color_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.new_x          = r_x;
  assign result.new_y          = r_y;
  assign result.new_z          = r_z;
  assign result.new_w          = r_w;
  assign result.derivative_out = r_de;
  assign result.distance_out   = r_dist;
  assign result.color_out      = r_color;

endmodule

FILE: src/kkf_front.sv
// Fold, scale and sum-of-squares front end: eight register stages.
// Depends on kkf_pkg.
module kkf_front #(
  parameter int FRACTION_BITS = kkf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] point_w,
  input  logic signed [31:0] derivative_in,
  input  logic [30:0]        distance_in,
  input  logic signed [31:0] color_in,
  input  logic [15:0]        iteration,
  input  logic signed [31:0] y_fold_scale,
  input  logic signed [31:0] main_scale,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [47:0]        swap_color_weights,
  input  logic [32:0]        color_window,
  output logic               out_valid,
  output logic [63:0]        pt_sq_sum,
  output logic [63:0]        off_sq_sum,
  output kkf_pkg::side_t     side
);
  import kkf_pkg::*;

  localparam longint THIRD_L = ((longint'(1) << FRACTION_BITS) + 1) / 3;
  localparam logic signed [31:0] THIRD32 = 32'(THIRD_L);
  localparam logic signed [39:0] THIRD   = 40'(THIRD_L);
  localparam logic signed [63:0] HALF64  = 64'(longint'(1) << (FRACTION_BITS - 1));
  localparam logic signed [65:0] HALF66  = 66'(longint'(1) << (FRACTION_BITS - 1));
  localparam logic signed [40:0] LIM     = 41'sd4294967295;

  function automatic logic signed [32:0] clampd(input logic signed [40:0] d);
    if (d > LIM) return 33'(LIM);
    else if (d < -LIM) return 33'(-LIM);
    else return d[32:0];
  endfunction

  function automatic logic signed [31:0] scale_out(input logic signed [64:0] p,
                                                  input logic signed [31:0] off);
    logic signed [65:0] r;
    r = ((66'(p) + HALF66) >>> FRACTION_BITS) + 66'(off);
    return sat32(64'(r));
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  logic [7:0] vld;

  // stage 1: absolute values, x/y swap, window check, fold position product
  logic [31:0]        ax, ay, x1, y1;
  logic signed [31:0] z1, w1, de1, color1;
  logic [30:0]        di1;
  logic signed [17:0] c1;
  logic               hit1;
  logic signed [63:0] yp1;
  logic               sw1;

  always_comb begin
    ax  = mag(point_x);
    ay  = mag(point_y);
    sw1 = ay > ax;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= sw1 ? ay : ax;
      y1     <= sw1 ? ax : ay;
      c1     <= sw1 ? 18'($signed(swap_color_weights[15:0])) : 18'sd0;
      z1     <= point_z;
      w1     <= point_w;
      de1    <= derivative_in;
      di1    <= distance_in;
      color1 <= color_in;
      hit1   <= color_window[32] && (iteration >= color_window[15:0]) &&
                (iteration < color_window[31:16]);
      yp1    <= 64'(y_fold_scale) * 64'(THIRD32);
    end
  end

  // stage 2: y mirror fold and the two shifted z/x swaps
  logic signed [39:0] yoff, yv, t, at, xa, za, xb, zb, xc, xd, zd;
  logic               sw2, sw3;
  logic signed [17:0] c2n;
  logic signed [39:0] x2, y2, z2;
  logic signed [31:0] w2, de2, color2;
  logic [30:0]        di2;
  logic signed [17:0] c2;
  logic               hit2;

  always_comb begin
    yoff = 40'((yp1 + HALF64) >>> FRACTION_BITS);
    yv   = $signed({8'd0, y1});
    t    = yv - yoff;
    at   = t[39] ? -t : t;
    xa   = $signed({8'd0, x1}) + THIRD;
    za   = 40'(z1);
    sw2  = za > xa;
    xb   = sw2 ? za : xa;
    zb   = sw2 ? xa : za;
    xc   = xb - THIRD - THIRD;
    sw3  = zb > xc;
    xd   = sw3 ? zb : xc;
    zd   = sw3 ? xc : zb;
    c2n  = c1 + (sw2 ? 18'($signed(swap_color_weights[31:16])) : 18'sd0)
              + (sw3 ? 18'($signed(swap_color_weights[47:32])) : 18'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2     <= xd + THIRD;
      y2     <= yoff - at;
      z2     <= zd;
      w2     <= w1;
      de2    <= de1;
      di2    <= di1;
      color2 <= color1;
      c2     <= c2n;
      hit2   <= hit1;
    end
  end

  // stage 3: differences to the offset, clamped
  logic signed [32:0] dx3, dy3, dz3, dw3;
  logic signed [31:0] de3, color3;
  logic [30:0]        di3;
  logic signed [17:0] c3;
  logic               hit3;

  always_ff @(posedge clk) begin
    if (en) begin
      dx3    <= clampd(41'(x2) - 41'(offset_x));
      dy3    <= clampd(41'(y2) - 41'(offset_y));
      dz3    <= clampd(41'(z2) - 41'(offset_z));
      dw3    <= clampd(41'(w2));
      de3    <= de2;
      di3    <= di2;
      color3 <= color2;
      c3     <= c2;
      hit3   <= hit2;
    end
  end

  // stage 4: scale products
  logic signed [64:0] px4, py4, pz4, pw4, pd4;
  logic signed [31:0] color4;
  logic [30:0]        di4;
  logic signed [17:0] c4;
  logic               hit4;

  always_ff @(posedge clk) begin
    if (en) begin
      px4    <= 65'(dx3) * 65'(main_scale);
      py4    <= 65'(dy3) * 65'(main_scale);
      pz4    <= 65'(dz3) * 65'(main_scale);
      pw4    <= 65'(dw3) * 65'(main_scale);
      pd4    <= 65'(de3) * 65'(main_scale);
      color4 <= color3;
      di4    <= di3;
      c4     <= c3;
      hit4   <= hit3;
    end
  end

  // stage 5: round, add offset back, saturate
  side_t s5, s6, s7, s8;

  always_ff @(posedge clk) begin
    if (en) begin
      s5.nx      <= scale_out(px4, offset_x);
      s5.ny      <= scale_out(py4, offset_y);
      s5.nz      <= scale_out(pz4, offset_z);
      s5.nw      <= scale_out(pw4, 32'sd0);
      s5.nde     <= scale_out(pd4, 32'sd0);
      s5.dist_in <= di4;
      s5.color   <= color4;
      s5.col     <= c4;
      s5.hit     <= hit4;
    end
  end

  // stage 6: squares of the new point and of the offset
  logic [31:0] mx, my, mz, mw, mox, moy, moz;
  logic [63:0] qx6, qy6, qz6, qw6, qox6, qoy6, qoz6;

  always_comb begin
    mx  = mag(s5.nx);
    my  = mag(s5.ny);
    mz  = mag(s5.nz);
    mw  = mag(s5.nw);
    mox = mag(offset_x);
    moy = mag(offset_y);
    moz = mag(offset_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx6  <= 64'(mx) * 64'(mx);
      qy6  <= 64'(my) * 64'(my);
      qz6  <= 64'(mz) * 64'(mz);
      qw6  <= 64'(mw) * 64'(mw);
      qox6 <= 64'(mox) * 64'(mox);
      qoy6 <= 64'(moy) * 64'(moy);
      qoz6 <= 64'(moz) * 64'(moz);
      s6   <= s5;
    end
  end

  // stage 7: pairwise sums
  logic [63:0] a7, b7, o7, oz7;

  always_ff @(posedge clk) begin
    if (en) begin
      a7  <= sat_add(qx6, qy6);
      b7  <= sat_add(qz6, qw6);
      o7  <= qox6 + qoy6;
      oz7 <= qoz6;
      s7  <= s6;
    end
  end

  // stage 8: final sums
  always_ff @(posedge clk) begin
    if (en) begin
      pt_sq_sum  <= sat_add(a7, b7);
      off_sq_sum <= o7 + oz7;
      s8         <= s7;
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  assign out_valid = vld[7];
  assign side      = s8;

endmodule

FILE: src/kkf_sqrt_pipe.sv
// Two-lane floor square root of 64-bit values, one result bit per stage.
// Depends on kkf_pkg for the side data type.
module kkf_sqrt_pipe (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    pt_val,
  input  logic [63:0]    off_val,
  input  kkf_pkg::side_t side_in,
  output logic           out_valid,
  output logic [31:0]    pt_root,
  output logic [31:0]    off_root,
  output kkf_pkg::side_t side_out
);
  import kkf_pkg::*;

  localparam int STAGES = 32;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] val;
  } lane_t;

  // bring down two bits, try subtracting 4*root+1
  function automatic lane_t step(input lane_t l);
    logic [34:0] r2;
    logic [34:0] trial;
    lane_t       o;
    r2    = {l.rem[32:0], l.val[63:62]};
    trial = {1'b0, l.root, 2'b01};
    o.val = {l.val[61:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {l.root[30:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {l.root[30:0], 1'b0};
    end
    return o;
  endfunction

  lane_t             pa [STAGES];
  lane_t             oa [STAGES];
  side_t             sd [STAGES];
  logic [STAGES-1:0] vld;
  lane_t             pin, oin;

  always_comb begin
    pin = '{rem: 35'd0, root: 32'd0, val: pt_val};
    oin = '{rem: 35'd0, root: 32'd0, val: off_val};
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= step(pin);
      oa[0] <= step(oin);
      sd[0] <= side_in;
      for (int k = 1; k < STAGES; k++) begin
        pa[k] <= step(pa[k-1]);
        oa[k] <= step(oa[k-1]);
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];
  assign pt_root   = pa[STAGES-1].root;
  assign off_root  = oa[STAGES-1].root;
  assign side_out  = sd[STAGES-1];

endmodule

FILE: src/kkf_div_pipe.sv
// Restoring divider, one quotient bit per stage, saturating at 2^31 - 1.
// Depends on kkf_pkg for the side data type.
module kkf_div_pipe #(
  parameter int FRACTION_BITS = kkf_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [FRACTION_BITS+32:0] num,
  input  logic [31:0]               den,
  input  kkf_pkg::side_t            side_in,
  output logic                      out_valid,
  output logic [30:0]               dist_q,
  output kkf_pkg::side_t            side_out
);
  import kkf_pkg::*;

  localparam int NUM_W  = FRACTION_BITS + 33;
  localparam int STAGES = NUM_W;

  typedef struct packed {
    logic [32:0]      rem;
    logic [NUM_W-1:0] num;
    logic [31:0]      den;
    logic [30:0]      q;
    logic             ovf;
  } lane_t;

  // shift in one numerator bit, subtract the divisor when it fits
  function automatic lane_t step(input lane_t l);
    logic [32:0] r2;
    lane_t       o;
    r2    = {l.rem[31:0], l.num[NUM_W-1]};
    o.num = {l.num[NUM_W-2:0], 1'b0};
    o.den = l.den;
    o.ovf = l.ovf | l.q[30];
    if (r2 >= {1'b0, l.den}) begin
      o.rem = r2 - {1'b0, l.den};
      o.q   = {l.q[29:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {l.q[29:0], 1'b0};
    end
    return o;
  endfunction

  lane_t             ln [STAGES];
  side_t             sd [STAGES];
  logic [STAGES-1:0] vld;
  lane_t             lin;

  always_comb begin
    lin = '{rem: 33'd0, num: num, den: den, q: 31'd0, ovf: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln[0] <= step(lin);
      sd[0] <= side_in;
      for (int k = 1; k < STAGES; k++) begin
        ln[k] <= step(ln[k-1]);
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];
  assign dist_q    = ln[STAGES-1].ovf ? '1 : ln[STAGES-1].q;
  assign side_out  = sd[STAGES-1];

endmodule

FILE: src/kkf_checker.sv
// Port-level checks of the Koch fold step unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kkf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_de,
  input logic [30:0] res_dist,
  input logic [31:0] res_x
);

  // input side is ready exactly when the output beat can move
  `KKF_ASSERT(a_ready_follows_output, clk, rst, in_ready == (!res_valid || res_ready), "ready mismatch")

  // zero derivative always reports the largest distance
  `KKF_ASSERT(a_zero_de_max_dist, clk, rst, (res_valid && res_de == 32'd0) |-> res_dist == 31'h7fffffff, "distance not saturated")

  // reset empties the pipe
  `KKF_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !res_valid, "result valid after reset")

  // a stalled beat stays
  `KKF_ASSERT(a_stall_holds_valid, clk, rst, (res_valid && !res_ready) |=> res_valid, "valid dropped")

  // a stalled beat keeps its payload
  `KKF_ASSERT(a_stall_holds_data, clk, rst, (res_valid && !res_ready) |=> ($stable(res_x) && $stable(res_dist)), "payload changed")

endmodule

bind koch_kifs_fold_step_unit kkf_checker u_kkf_checker (
  .clk(clk), .rst(rst), .in_ready(item.ready),
  .res_valid(result.valid), .res_ready(result.ready),
  .res_de(result.derivative_out), .res_dist(result.distance_out),
  .res_x(result.new_x)
);
